// ----- hw/rtl/range_min_segment_tree_top_defines.svh -----
// Assertion macros for the range-minimum segment tree.
`ifndef RANGE_MIN_SEGMENT_TREE_TOP_DEFINES_SVH
`define RANGE_MIN_SEGMENT_TREE_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define RMST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define RMST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hw/rtl/rmst_pkg.sv -----
// Shared types and constants of the range-minimum segment tree.
package rmst_pkg;
	localparam int MaxElements = 1024;
	localparam int LeafBits = $clog2(MaxElements);
	localparam int NodeBits = LeafBits + 1;
	localparam int CountBits = LeafBits + 1;
	localparam logic signed [31:0] MinIdentity = 32'sh7FFF_FFFF;

	typedef enum logic {
		FUNC_SET = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	// A classified command from the front end to the executor.
	typedef struct packed {
		logic is_query;
		logic is_empty;
		logic [LeafBits-1:0] lo;
		logic [LeafBits-1:0] hi;
		logic signed [31:0] value;
	} cmd_t;
endpackage

// ----- hw/rtl/rmst_front.sv -----
// Front end: accepts input words, clips ranges and queues commands.
module rmst_front (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic s_axis_tuser,
	input logic [rmst_pkg::CountBits-1:0] n_in_use,
	output logic cmd_valid,
	input logic cmd_ready,
	output rmst_pkg::cmd_t cmd
);
	import rmst_pkg::*;

	localparam int Depth = 2;
	cmd_t fifo_q [Depth];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic func;
	logic [LeafBits-1:0] pos, lo, hi, hi_clip;
	logic [CountBits-1:0] n_m1;
	logic take, give, keep;
	cmd_t new_cmd;

	assign func = s_axis_tuser;
	assign pos = s_axis_tdata[9:0];
	assign lo = s_axis_tdata[51:42];
	assign hi = s_axis_tdata[61:52];
	assign n_m1 = n_in_use - CountBits'(1);
	assign hi_clip = ({1'b0, hi} > n_m1) ? n_m1[LeafBits-1:0] : hi;

	always_comb begin
		new_cmd.is_query = (func == FUNC_QUERY);
		new_cmd.is_empty = (lo > hi_clip);
		new_cmd.lo = new_cmd.is_query ? lo : pos;
		new_cmd.hi = hi_clip;
		new_cmd.value = $signed(s_axis_tdata[41:10]);
	end

	// Sets beyond the positions in use are dropped here.
	assign keep = (func == FUNC_QUERY) || ({1'b0, pos} < n_in_use);
	assign s_axis_tready = (count_q != 2'd2);
	assign take = s_axis_tvalid && s_axis_tready;
	assign cmd_valid = (count_q != 2'd0);
	assign give = cmd_valid && cmd_ready;
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (take && keep) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (take && keep) wr_ptr_q <= ~wr_ptr_q;
			if (give) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(take && keep) - 2'(give);
		end
	end
endmodule

// ----- hw/rtl/rmst_back.sv -----
// Back end: walks the tree memory for updates and range queries.
module rmst_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input rmst_pkg::cmd_t cmd,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata,
	output logic m_axis_tuser,
	output logic busy
);
	import rmst_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_UP_RD, ST_UP_WAIT, ST_UP_WR,
		ST_Q_STEP, ST_Q_WAIT, ST_OUT
	} state_t;

	state_t state_q;
	logic signed [31:0] mem [2*MaxElements];
	logic signed [31:0] rd_data_q;
	logic [NodeBits-1:0] rd_addr;
	logic rd_en;
	logic [NodeBits-1:0] wr_addr;
	logic signed [31:0] wr_data;
	logic wr_en;

	logic [NodeBits-1:0] k_q;
	logic [NodeBits:0] l_q, r_q;
	logic signed [31:0] val_q, best_q, sib_q;
	logic empty_q, pend_r_q;
	logic signed [31:0] res_min_q;
	logic res_empty_q;
	logic signed [31:0] cand;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign cand = (rd_data_q < best_q) ? rd_data_q : best_q;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = k_q ^ NodeBits'(1);
		wr_en = 1'b0;
		wr_addr = k_q;
		wr_data = val_q;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_data = MinIdentity;
			end
			ST_UP_RD: rd_en = 1'b1;
			ST_UP_WR: wr_en = 1'b1;
			ST_Q_STEP: begin
				rd_en = 1'b1;
				rd_addr = (l_q[0] && !pend_r_q) ? l_q[NodeBits-1:0]
					: NodeBits'(r_q - 1'b1);
			end
			default: ;
		endcase
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = res_min_q;
	assign m_axis_tuser = res_empty_q;
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			k_q <= '0;
			l_q <= '0;
			r_q <= '0;
			val_q <= '0;
			best_q <= '0;
			sib_q <= '0;
			empty_q <= 1'b0;
			pend_r_q <= 1'b0;
			res_min_q <= '0;
			res_empty_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					k_q <= k_q + NodeBits'(1);
					if (k_q == NodeBits'(2*MaxElements-1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (cmd_valid) begin
					if (!cmd.is_query) begin
						k_q <= NodeBits'(MaxElements) + NodeBits'(cmd.lo);
						val_q <= cmd.value;
						state_q <= ST_UP_WR;
					end else if (cmd.is_empty) begin
						res_min_q <= MinIdentity;
						res_empty_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						l_q <= (NodeBits+1)'(MaxElements) + (NodeBits+1)'(cmd.lo);
						r_q <= (NodeBits+1)'(MaxElements) + (NodeBits+1)'(cmd.hi)
							+ (NodeBits+1)'(1);
						best_q <= MinIdentity;
						pend_r_q <= 1'b0;
						empty_q <= 1'b0;
						state_q <= ST_Q_STEP;
					end
				end
				// Write the current node, then read its sibling to form the parent.
				ST_UP_WR: begin
					if (k_q == NodeBits'(1)) state_q <= ST_IDLE;
					else state_q <= ST_UP_RD;
				end
				ST_UP_RD: state_q <= ST_UP_WAIT;
				ST_UP_WAIT: begin
					val_q <= (rd_data_q < val_q) ? rd_data_q : val_q;
					k_q <= k_q >> 1;
					state_q <= ST_UP_WR;
				end
				ST_Q_STEP: begin
					if (l_q >= r_q) begin
						res_min_q <= best_q;
						res_empty_q <= empty_q;
						state_q <= ST_OUT;
					end else if (l_q[0] && !pend_r_q) begin
						l_q <= l_q + (NodeBits+1)'(1);
						pend_r_q <= 1'b1;
						sib_q <= '0;
						state_q <= ST_Q_WAIT;
					end else if (r_q[0]) begin
						r_q <= r_q - (NodeBits+1)'(1);
						pend_r_q <= 1'b0;
						sib_q <= 32'sd1;
						state_q <= ST_Q_WAIT;
					end else begin
						l_q <= l_q >> 1;
						r_q <= r_q >> 1;
						pend_r_q <= 1'b0;
					end
				end
				ST_Q_WAIT: begin
					best_q <= cand;
					if (sib_q[0]) begin
						l_q <= l_q >> 1;
						r_q <= r_q >> 1;
						pend_r_q <= 1'b0;
					end else if (!r_q[0]) begin
						l_q <= l_q >> 1;
						r_q <= r_q >> 1;
						pend_r_q <= 1'b0;
					end
					state_q <= ST_Q_STEP;
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/range_min_segment_tree_top.sv -----
// Top level of the range-minimum segment tree.
// The block keeps up to 1024 signed 32-bit values as a tree of minimums.
// Input words on s_axis: a set word writes one position and refreshes its
// ancestors, a query word returns one result word on m_axis with the minimum
// over the inclusive range, clipped to the positions in use, and a flag when
// that range is empty. Sets beyond the positions in use are dropped.
// The cfg channel writes elements_in_use; write it only while idle.
// A two-entry command queue separates the front end, which accepts and
// classifies words, from the back end, which walks the single-port tree
// memory. A set writes the node and reads its sibling on each of the ten
// levels; a query reads each covering node and then steps up a level. The
// result is registered and held in ST_OUT once the walk ends.
// After reset the back end clears all 2048 nodes, one per cycle, before
// it takes a command; the front end may already queue two words.
// When m_axis stalls the result is held, the queue fills, then s_axis_tready
// falls until the result is taken.
module range_min_segment_tree_top (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// position[9:0], value[41:10], left_index[51:42], right_index[61:52]
	input logic [63:0] s_axis_tdata,
	// func[0]
	input logic s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// minimum[31:0]
	output logic [31:0] m_axis_tdata,
	// range_empty[0]
	output logic m_axis_tuser,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [10:0] cfg_data
);
	import rmst_pkg::*;
	`include "range_min_segment_tree_top_defines.svh"

	logic [CountBits-1:0] n_q;
	logic cmd_valid, cmd_ready, busy;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	// Out-of-range writes are clamped to 1..MaxElements.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CountBits'(MaxElements);
		end else if (cfg_valid) begin
			if (cfg_data == '0) n_q <= CountBits'(1);
			else if ({{(32-11){1'b0}}, cfg_data} > 32'(MaxElements))
				n_q <= CountBits'(MaxElements);
			else n_q <= CountBits'(cfg_data);
		end
	end

	rmst_front u_front (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.n_in_use(n_q), .cmd_valid, .cmd_ready, .cmd
	);

	rmst_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .busy
	);

	`RMST_ASSERT_IMP(a_ready_idle, clk, arst_n, cmd_ready, !busy, "back end took command while busy")
	`RMST_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
	`RMST_ASSERT_IMP(a_n_range, clk, arst_n, 1'b1, n_q != '0 && n_q <= CountBits'(MaxElements), "element count out of range")
endmodule

// ----- sim/rmst_checker.sv -----
// Checker that predicts and compares the result words of the range-minimum segment tree.
`timescale 1ns / 1ps
module rmst_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic m_axis_tuser,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [10:0] cfg_data,
	output int fail_count,
	output int pending_results,
	output int query_count,
	output int empty_count
);
	import rmst_pkg::*;

	typedef struct packed {
		logic signed [31:0] minimum;
		logic range_empty;
	} min_result_t;

	logic signed [31:0] min_tree [2*MaxElements];
	int unsigned span;
	min_result_t min_results [$];

	function automatic logic signed [31:0] smaller(logic signed [31:0] a, logic signed [31:0] b);
		return (a < b) ? a : b;
	endfunction

	// Walk the tree bottom-up over the half-open node span [l, r).
	function automatic logic signed [31:0] tree_min(int unsigned lo, int unsigned hi);
		logic signed [31:0] best;
		int unsigned l, r;
		best = MinIdentity;
		l = lo + MaxElements;
		r = hi + MaxElements + 1;
		while (l < r) begin
			if (l[0]) begin
				best = smaller(best, min_tree[l]);
				l++;
			end
			if (r[0]) begin
				r--;
				best = smaller(best, min_tree[r]);
			end
			l = l >> 1;
			r = r >> 1;
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int unsigned k, pos, lo, hi;
		int errs;
		min_result_t want, got;
		errs = 0;
		if (!arst_n) begin
			foreach (min_tree[i]) min_tree[i] = MinIdentity;
			span = MaxElements;
			min_results.delete();
			fail_count <= 0;
			pending_results <= 0;
			query_count <= 0;
			empty_count <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (func_t'(s_axis_tuser) == FUNC_SET) begin
					pos = s_axis_tdata[9:0];
					if (pos < span) begin
						k = pos + MaxElements;
						min_tree[k] = s_axis_tdata[41:10];
						while (k > 1) begin
							k = k >> 1;
							min_tree[k] = smaller(min_tree[2*k], min_tree[2*k+1]);
						end
					end
				end else begin
					lo = s_axis_tdata[51:42];
					hi = s_axis_tdata[61:52];
					if (hi > span - 1) hi = span - 1;
					if (lo > hi) begin
						want = '{MinIdentity, 1'b1};
						empty_count <= empty_count + 1;
					end else begin
						want = '{tree_min(lo, hi), 1'b0};
					end
					min_results.push_back(want);
					query_count <= query_count + 1;
				end
			end
			// The register takes effect for words accepted after this edge.
			if (cfg_valid && cfg_ready) begin
				span = (cfg_data == 0) ? 1 : (cfg_data > MaxElements) ? MaxElements : cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata, m_axis_tuser};
				if (min_results.size() == 0) begin
					$error("unexpected result word: minimum %0d range_empty %0b",
						got.minimum, got.range_empty);
					errs++;
				end else begin
					want = min_results.pop_front();
					if (got.minimum !== want.minimum) begin
						$error("minimum: expected %0d, actual %0d", want.minimum, got.minimum);
						errs++;
					end
					if (got.range_empty !== want.range_empty) begin
						$error("range_empty: expected %0b, actual %0b",
							want.range_empty, got.range_empty);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
			pending_results <= min_results.size();
		end
	end
endmodule

// ----- sim/tb_range_min_segment_tree_top.sv -----
// Testbench top: drives words into the range-minimum segment tree and gives the verdict.
`timescale 1ns / 1ps
module tb_range_min_segment_tree_top;
	import rmst_pkg::*;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// position[9:0], value[41:10], left_index[51:42], right_index[61:52]
	logic [63:0] s_axis_tdata;
	// func[0]
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// minimum[31:0]
	logic [31:0] m_axis_tdata;
	// range_empty[0]
	logic m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [10:0] cfg_data;

	int fail_count, pending_results, query_count, empty_count;
	int unsigned cycle_count;
	int unsigned span;
	logic long_hold_req;
	int words_sent;

	// The limit allows for the block's tree walk on every word, plus the longest
	// sender gap and receiver stall, with a wide margin.
	localparam int unsigned CycleLimit = 600000;

	range_min_segment_tree_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	rmst_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_results(pending_results),
		.query_count(query_count),
		.empty_count(empty_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The cycle counter doubles as a watchdog for a hung handshake.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CycleLimit) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Gaps are often zero; now and then one runs long.
	function automatic int unsigned gap_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// The receiver stalls at random. On request it holds off for a long
	// stretch so the command queue fills and s_axis_tready drops, then
	// takes every word until the request is withdrawn.
	initial begin
		int unsigned stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
				m_axis_tready <= 1'b1;
				while (long_hold_req) @(posedge clk);
			end else if (words_sent < 150 || words_sent > 900) begin
				// Stretches with no stall at all.
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				stall = gap_length();
				if (stall != 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one word and hold it until accepted.
	task automatic send_word(input func_t func, input logic [9:0] pos, input logic [31:0] value,
			input logic [9:0] lo, input logic [9:0] hi);
		s_axis_tdata <= {2'b00, hi, lo, value, pos};
		s_axis_tuser <= func;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
	endtask

	task automatic go_idle(input int unsigned pause);
		s_axis_tvalid <= 1'b0;
		if (pause != 0) repeat (pause) @(posedge clk);
	endtask

	task automatic send_set(input logic [9:0] pos, input logic [31:0] value);
		send_word(FUNC_SET, pos, value, 10'($urandom), 10'($urandom));
	endtask

	task automatic send_query(input logic [9:0] lo, input logic [9:0] hi);
		send_word(FUNC_QUERY, 10'($urandom), $urandom, lo, hi);
	endtask

	// Wait until every result has arrived, then let the sets still queued
	// or walking the tree finish before the register changes.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_span(input logic [10:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		span = (value == 0) ? 1 : (value > MaxElements) ? MaxElements : value;
	endtask

	// Random values lean on the extremes so ties and INT_MAX show up.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [9:0] pick_index();
		if ($urandom_range(0, 9) < 8) return 10'($urandom_range(0, span - 1));
		return 10'($urandom);
	endfunction

	// One phase: mostly sets and queries inside the span, some out of it.
	task automatic random_phase(input int count);
		logic [9:0] a, b;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				send_set(pick_index(), pick_value());
			end else begin
				a = pick_index();
				b = pick_index();
				if ($urandom_range(0, 9) < 7 && a > b) send_query(b, a);
				else send_query(a, b);
			end
			if ($urandom_range(0, 3) == 0) go_idle(gap_length());
		end
	endtask

	initial begin
		logic [10:0] spans [6];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		long_hold_req = 1'b0;
		words_sent = 0;
		span = MaxElements;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fresh store, extremes of fields and values.
		send_query(0, 10'h3FF);
		send_set(0, 32'h8000_0000);
		send_set(10'h3FF, 32'h7FFF_FFFF);
		send_set(512, 32'hFFFF_FFFF);
		send_query(0, 0);
		send_query(10'h3FF, 10'h3FF);
		send_query(1, 10'h3FF);
		send_query(513, 10'h3FF);
		send_query(700, 300);
		send_set(10'h155, 32'h5555_5555);
		send_set(10'h2AA, 32'hAAAA_AAAA);
		send_query(10'h155, 10'h2AA);
		drain();

		// Small span: sets beyond it are dropped, queries are clipped.
		write_span(0);
		send_set(0, 32'd7);
		send_set(1, 32'h8000_0001);
		send_query(0, 10'h3FF);
		send_query(1, 5);
		drain();
		write_span(11'h7FF);
		send_query(0, 10'h3FF);
		drain();
		write_span(5);
		send_set(4, 32'd3);
		send_set(5, 32'h8000_0000);
		send_query(2, 10'h3FF);
		send_query(5, 9);
		drain();

		spans = '{11'd1024, 11'd1, 11'd2, 11'd37, 11'd700, 11'd1024};
		foreach (spans[p]) begin
			write_span(spans[p]);
			random_phase(p == 4 ? 180 : 150);
			if (p == 2) begin
				// Sender pauses until every expected result has come.
				drain();
			end
			if (p == 3) begin
				// Receiver holds off while the sender keeps offering.
				long_hold_req <= 1'b1;
				random_phase(40);
				long_hold_req <= 1'b0;
			end
			drain();
		end

		wait (pending_results == 0);
		repeat (80) @(posedge clk);
		$display("covered %0d words, %0d queries (%0d empty), spans from 1 to 1024",
			words_sent, query_count, empty_count);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
